// ===== rtl/min_coin_change_dp_top_assert.svh =====
// assertion macros for the coin change block
`ifndef MIN_COIN_CHANGE_DP_TOP_ASSERT_SVH
`define MIN_COIN_CHANGE_DP_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define MCC_ASSERT_IMP(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("implication check failed");

`define MCC_ASSERT_NXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("next cycle check failed");

`else

`define MCC_ASSERT_IMP(lbl, ck, rn, pre, post)

`define MCC_ASSERT_NXT(lbl, ck, rn, pre, post)

`endif

`endif

// ===== rtl/mcc_pkg.sv =====
// shared types and constants for the coin change block
`default_nettype none

package mcc_pkg;

  localparam int TABLE_DEPTH   = 4096;
  localparam int MAX_COINS     = 6;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int COIN_W        = 12;
  localparam int AMT_W         = 12;
  localparam int CNT_W         = 12;
  localparam int ENTRY_W       = CNT_W + 1;
  localparam int NUM_COIN_REGS = 6;
  localparam int NCOIN_W       = 3;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COIN_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_0     = 3'd1;

  localparam logic [NCOIN_W-1:0] COIN_COUNT_RESET = 3'd5;
  localparam logic [NUM_COIN_REGS-1:0][COIN_W-1:0] COIN_RESET =
    {12'd1, 12'd5, 12'd4, 12'd3, 12'd2, 12'd1};

  typedef struct packed {
    logic [NCOIN_W-1:0]                     ncoins;
    logic [NUM_COIN_REGS-1:0][COIN_W-1:0]   coin;
  } coin_set_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] min_coins;
    logic             unreachable;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/mcc_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none

module mcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/mcc_cfg.sv =====
// configuration registers for coin count and denominations
`default_nettype none

module mcc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mcc_pkg::COIN_W-1:0]    cfg_data,
  output mcc_pkg::coin_set_t                 coins
);

  import mcc_pkg::*;

  logic [NCOIN_W-1:0]                   count_r;
  logic [NUM_COIN_REGS-1:0][COIN_W-1:0] coin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COIN_COUNT_RESET;
      coin_r  <= COIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_COIN_COUNT) begin
        count_r <= cfg_data[NCOIN_W-1:0];
      end else if ((32'(cfg_index) >= 32'(REG_COIN_0)) &&
                   (32'(cfg_index) < 32'(REG_COIN_0) + NUM_COIN_REGS)) begin
        coin_r[CFG_IDX_W'(cfg_index - REG_COIN_0)] <= cfg_data;
      end
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    coins.coin = coin_r;
    if (32'(count_r) > MAX_COINS) begin
      coins.ncoins = NCOIN_W'(MAX_COINS);
    end else begin
      coins.ncoins = count_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mcc_core.sv =====
// table sequencer: rebuilds best counts in memory, one coin read per cycle
`default_nettype none

module mcc_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  mcc_pkg::coin_set_t             coins,
  input  wire logic                      start,
  input  wire logic [mcc_pkg::AMT_W-1:0] start_target,
  input  wire logic                      ack,
  output logic                           idle,
  output mcc_pkg::result_t               res
);

  import mcc_pkg::*;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  tgt_r, tgt_nxt;
  logic [ADDR_W-1:0]  amt_r, amt_nxt;
  logic [NCOIN_W-1:0] ncoins_r, ncoins_nxt;
  logic [NCOIN_W-1:0] cidx_r, cidx_nxt;
  logic               pend_r, pend_nxt;
  logic               pusable_r, pusable_nxt;
  logic               found_r, found_nxt;
  logic [CNT_W-1:0]   best_r, best_nxt;
  logic [CNT_W-1:0]   res_cnt_r, res_cnt_nxt;
  logic               res_unr_r, res_unr_nxt;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [ENTRY_W-1:0] rdata;

  logic [COIN_W-1:0]  cur_coin;
  logic               usable;
  logic               hit;
  logic [CNT_W-1:0]   cand;
  logic               found_c;
  logic [CNT_W-1:0]   best_c;
  logic               trivial;
  logic               last_step;
  logic               out_of_range;

  mcc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    if (32'(cidx_r) < NUM_COIN_REGS) begin
      cur_coin = coins.coin[cidx_r];
    end else begin
      cur_coin = '0;
    end
    usable       = (cur_coin != '0) && (32'(cur_coin) <= 32'(amt_r));
    hit          = pend_r && pusable_r && !rdata[CNT_W];
    cand         = rdata[CNT_W-1:0] + CNT_W'(1);
    found_c      = found_r || hit;
    best_c       = (hit && (!found_r || (cand < best_r))) ? cand : best_r;
    last_step    = pend_r && (cidx_r == ncoins_r);
    out_of_range = 32'(start_target) >= TABLE_DEPTH;
    trivial      = out_of_range || (start_target == '0) || (coins.ncoins == '0);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = trivial ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_step && (amt_r == tgt_r)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory access
  always_comb begin
    tgt_nxt     = tgt_r;
    amt_nxt     = amt_r;
    ncoins_nxt  = ncoins_r;
    cidx_nxt    = cidx_r;
    pend_nxt    = pend_r;
    pusable_nxt = pusable_r;
    found_nxt   = found_r;
    best_nxt    = best_r;
    res_cnt_nxt = res_cnt_r;
    res_unr_nxt = res_unr_r;
    we          = 1'b0;
    waddr       = amt_r;
    wdata       = '0;
    raddr       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          tgt_nxt     = ADDR_W'(start_target);
          amt_nxt     = ADDR_W'(1);
          ncoins_nxt  = coins.ncoins;
          cidx_nxt    = '0;
          pend_nxt    = 1'b0;
          found_nxt   = 1'b0;
          best_nxt    = '0;
          res_cnt_nxt = '0;
          res_unr_nxt = out_of_range || (start_target != '0);
          if (!trivial) begin
            we    = 1'b1;
            waddr = '0;
            wdata = '0;
          end
        end
      end
      ST_RUN: begin
        found_nxt = found_c;
        best_nxt  = best_c;
        if (cidx_r < ncoins_r) begin
          raddr       = ADDR_W'(32'(amt_r) - 32'(cur_coin));
          pend_nxt    = 1'b1;
          pusable_nxt = usable;
          cidx_nxt    = cidx_r + NCOIN_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (last_step) begin
          we    = 1'b1;
          waddr = amt_r;
          wdata = found_c ? {1'b0, best_c} : {1'b1, {CNT_W{1'b0}}};
          if (amt_r == tgt_r) begin
            res_cnt_nxt = found_c ? best_c : '0;
            res_unr_nxt = !found_c;
          end else begin
            amt_nxt   = amt_r + ADDR_W'(1);
            cidx_nxt  = '0;
            found_nxt = 1'b0;
            best_nxt  = '0;
          end
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    idle            = (state_r == ST_IDLE);
    res.valid       = (state_r == ST_DONE);
    res.min_coins   = res_cnt_r;
    res.unreachable = res_unr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      cidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      cidx_r  <= cidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r     <= tgt_nxt;
    amt_r     <= amt_nxt;
    ncoins_r  <= ncoins_nxt;
    pusable_r <= pusable_nxt;
    found_r   <= found_nxt;
    best_r    <= best_nxt;
    res_cnt_r <= res_cnt_nxt;
    res_unr_r <= res_unr_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/min_coin_change_dp_top.sv =====
// top level of the minimum coin change block
`default_nettype none

// Each item carries a target amount and returns the fewest coins that sum to
// it, or an unreachable flag with a zero count. The best count table sits in
// one 4096 x 13 memory with a single read port, and the sequencer rebuilds it
// from amount 1 up to the target for every item, reading one coin's entry per
// cycle. Target zero, no active coins or a target past the table end skip the
// rebuild and go straight to the result. The table holds no reset contents and
// needs no clearing pass. A new item is taken as soon as the sequencer is idle,
// even while the previous result still waits in the output register.

`include "min_coin_change_dp_top_assert.svh"

module min_coin_change_dp_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mcc_pkg::AMT_W-1:0]     in_target_amount,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [mcc_pkg::CNT_W-1:0]     out_min_coins,
  output logic                               out_unreachable,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mcc_pkg::COIN_W-1:0]    cfg_data
);

  import mcc_pkg::*;

  coin_set_t        coins;
  result_t          res;
  logic             core_idle;
  logic             start;
  logic             push;
  logic             out_valid_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_unr_r;

  mcc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .coins    (coins)
  );

  mcc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .coins       (coins),
    .start       (start),
    .start_target(in_target_amount),
    .ack         (push),
    .idle        (core_idle),
    .res         (res)
  );

  assign in_stall = !core_idle;
  assign start    = in_valid && !in_stall;
  assign push     = res.valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_cnt_r <= res.min_coins;
      out_unr_r <= res.unreachable;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_min_coins   = out_cnt_r;
  assign out_unreachable = out_unr_r;

  `MCC_ASSERT_IMP(a_unr_zero, clk, rst_n, out_valid && out_unreachable, out_min_coins == '0)
  `MCC_ASSERT_NXT(a_busy_after_take, clk, rst_n, start, in_stall)
  `MCC_ASSERT_IMP(a_push_into_free, clk, rst_n, push, !(out_valid_r && out_stall))
  `MCC_ASSERT_IMP(a_idle_no_result, clk, rst_n, core_idle, !res.valid)

endmodule

`default_nettype wire
